>>> sv/color_line_led_decoder_defines.svh
// Assertion macros for the colour line LED decoder.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef COLOR_LINE_LED_DECODER_DEFINES_SVH
`define COLOR_LINE_LED_DECODER_DEFINES_SVH

// Checked outside reset only
`define CLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define CLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cld_pkg.sv
// Shared types, constants and keyword helpers for the colour line LED decoder.
// No dependencies.
`default_nettype none

package cld_pkg;

  localparam int LINE_LIMIT_DEFAULT = 63;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_COMMA = 8'd44;
  localparam logic [7:0] BYTE_NUL   = 8'd0;

  // keyword bit positions in a match mask
  localparam int KW_RED    = 0;
  localparam int KW_BLUE   = 1;
  localparam int KW_YELLOW = 2;

  localparam logic [2:0] LEN_RED    = 3'd3;
  localparam logic [2:0] LEN_BLUE   = 3'd4;
  localparam logic [2:0] LEN_YELLOW = 3'd6;
  localparam logic [2:0] POS_MAX    = 3'd7;

  typedef enum logic [1:0] {
    TK_CHAR,
    TK_COMMA,
    TK_NUL,
    TK_EOL
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;    // byte with A-Z folded to lower case
  } token_t;

  // Per keyword: does the keyword have character c at position pos?
  function automatic logic [2:0] kw_step(logic [2:0] pos, logic [7:0] c);
    logic [2:0] m;
    m = 3'b000;
    unique case (pos)
      3'd0: m = {c == "y", c == "b", c == "r"};
      3'd1: m = {c == "e", c == "l", c == "e"};
      3'd2: m = {c == "l", c == "u", c == "d"};
      3'd3: m = {c == "l", c == "e", 1'b0};
      3'd4: m = {c == "o", 2'b00};
      3'd5: m = {c == "w", 2'b00};
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // Keywords fully matched by a field of pos characters
  function automatic logic [2:0] field_flags(logic [2:0] pos, logic [2:0] alive);
    logic [2:0] f;
    f = 3'b000;
    if (pos != 3'd0) begin
      f[KW_RED]    = alive[KW_RED]    && (pos == LEN_RED);
      f[KW_BLUE]   = alive[KW_BLUE]   && (pos == LEN_BLUE);
      f[KW_YELLOW] = alive[KW_YELLOW] && (pos == LEN_YELLOW);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> sv/cld_front.sv
// Front end: takes received bytes, classifies them and folds case.
// Depends on cld_pkg; feeds cld_fifo.
`default_nettype none

module cld_front
  import cld_pkg::*;
(
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output      logic       q_push,
  output      token_t     q_token
);

  always_comb begin
    in_stall = q_full;
    q_push   = in_valid && !q_full;
  end

  always_comb begin
    q_token.ch = rx_byte;
    if (rx_byte >= "A" && rx_byte <= "Z") begin
      q_token.ch = rx_byte + 8'd32;
    end
    priority if (rx_byte == BYTE_LF || rx_byte == BYTE_CR) begin
      q_token.kind = TK_EOL;
    end else if (rx_byte == BYTE_COMMA) begin
      q_token.kind = TK_COMMA;
    end else if (rx_byte == BYTE_NUL) begin
      q_token.kind = TK_NUL;
    end else begin
      q_token.kind = TK_CHAR;
    end
  end

endmodule

`default_nettype wire

>>> sv/cld_fifo.sv
// Short token queue between front and back ends.
// Depends on cld_pkg for the token type.
`default_nettype none

module cld_fifo
  import cld_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire token_t                 push_token,
  input  wire logic                   pop,
  output      logic                   full,
  output      logic                   head_valid,
  output      token_t                 head,
  output      logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  token_t        entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] used;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full       = (used == CW'(DEPTH));
  assign head_valid = (used != '0);
  assign head       = entries[rd_ptr];
  assign count      = used;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   used <= used + CW'(1);
        2'b01:   used <= used - CW'(1);
        default: used <= used;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/cld_back.sv
// Back end: line and field state, keyword matching and the result register.
// Depends on cld_pkg; takes tokens from cld_fifo.
`default_nettype none

module cld_back
  import cld_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire token_t      head,
  output      logic        pop,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        led_red,
  output      logic        led_blue,
  output      logic        led_yellow,
  output      logic        led_changed,
  output      logic [31:0] line_count
);

  localparam int KW = $clog2(LINE_LIMIT + 1);

  logic [KW-1:0] kept;
  logic          second;
  logic          term;
  logic [2:0]    pos;
  logic [2:0]    alive;
  logic [2:0]    first_flags;
  logic [2:0]    led_pattern;
  logic [31:0]   lines;

  logic       out_free;
  logic       emit;
  logic [2:0] cur_flags;
  logic [2:0] mask;

  always_comb begin
    out_free  = !out_valid || !out_stall;
    emit      = head_valid && (head.kind == TK_EOL) && (kept != '0);
    pop       = head_valid && (!emit || out_free);
    cur_flags = field_flags(pos, alive);
    mask      = second ? (first_flags | cur_flags) : cur_flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept        <= '0;
      second      <= 1'b0;
      term        <= 1'b0;
      pos         <= '0;
      alive       <= '1;
      first_flags <= '0;
      led_pattern <= '0;
      lines       <= '0;
    end else if (pop) begin
      if (head.kind == TK_EOL) begin
        if (emit) begin
          led_pattern <= mask;
          lines       <= lines + 32'd1;
        end
        kept        <= '0;
        second      <= 1'b0;
        first_flags <= '0;
        term        <= 1'b0;
        pos         <= '0;
        alive       <= '1;
      end else if (kept != KW'(LINE_LIMIT)) begin
        kept <= kept + KW'(1);
        if (head.kind == TK_COMMA && !second) begin
          first_flags <= cur_flags;
          second      <= 1'b1;
          term        <= 1'b0;
          pos         <= '0;
          alive       <= '1;
        end else if (!term) begin
          if (head.kind == TK_NUL) begin
            term <= 1'b1;
          end else begin
            alive <= alive & kw_step(pos, head.ch);
            if (pos != POS_MAX) begin
              pos <= pos + 3'd1;
            end
          end
        end
      end
    end
  end

  // result register: reloads as soon as the held item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && pop) begin
      led_red     <= mask[KW_RED];
      led_blue    <= mask[KW_BLUE];
      led_yellow  <= mask[KW_YELLOW];
      led_changed <= (mask != led_pattern);
      line_count  <= lines + 32'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/color_line_led_decoder.sv
// Colour line LED decoder, top level.
// Input channel: rx_byte with in_valid/in_stall; one byte per item.
// Output channel: led_red, led_blue, led_yellow, led_changed, line_count with
// out_valid/out_stall; one item per non-empty line, issued on its CR or LF.
// A byte is taken whenever in_valid is high and in_stall low; in_stall rises
// only when the token queue holds QUEUE_DEPTH bytes.
// Throughput: one byte per cycle while in_stall is low. The front end
// classifies the byte and pushes it into the queue; the back end consumes
// one queued byte a cycle unless a line end waits on a held result. A
// line end passes through the queue, then the result register when free.
// While out_stall holds a result, the back end keeps consuming bytes until it
// meets the next non-empty line end, which waits at the head of the queue;
// the queue then fills and in_stall rises.
// Reset (rst, synchronous) empties the queue, drops the result register and
// clears the line state, the LED pattern and the line count.
// Bytes past LINE_LIMIT in a line are dropped; only the first comma splits.
`default_nettype none
`include "color_line_led_decoder_defines.svh"

module color_line_led_decoder
  import cld_pkg::*;
#(
  parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  rx_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        led_red,
  output      logic        led_blue,
  output      logic        led_yellow,
  output      logic        led_changed,
  output      logic [31:0] line_count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          q_full;
  logic          q_push;
  token_t        q_token;
  logic          q_pop;
  logic          q_head_valid;
  token_t        q_head;
  logic [CW-1:0] q_count;

  cld_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_token  (q_token)
  );

  cld_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_token (q_token),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .count      (q_count)
  );

  cld_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_red     (led_red),
    .led_blue    (led_blue),
    .led_yellow  (led_yellow),
    .led_changed (led_changed),
    .line_count  (line_count)
  );

  `CLD_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !out_valid, "result valid after reset")
  `CLD_ASSERT(a_queue_bound, q_count <= CW'(QUEUE_DEPTH), "token queue overflow")
  `CLD_ASSERT(a_stall_when_full, (q_count == CW'(QUEUE_DEPTH)) |-> in_stall, "byte taken into full queue")
  `CLD_ASSERT(a_count_steps, (out_valid && !out_stall) |=> (!out_valid || line_count == $past(line_count) + 32'd1), "line count skipped")

endmodule

`default_nettype wire
